// File: src/assert_macros.svh
// Assertion macros shared by the tile name parser RTL.
// Depends on nothing; active only when SYNTHESIS is not defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("property check failed");
// Check that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: src/tnp_pkg.sv
// Types and constants of the tile name parser.
// Used by tnp_step and tile_name_parser; depends on nothing.
package tnp_pkg;

	// Position in the name t_X_Y
	typedef enum logic [3:0] {
		PH_T   = 4'b0001,
		PH_SEP = 4'b0010,
		PH_X   = 4'b0100,
		PH_Y   = 4'b1000
	} phase_t;

	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Largest magnitude a number may reach (2^31)
	localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
	// Largest positive magnitude
	localparam logic [31:0] MAG_POS_MAX = 32'h7fff_ffff;

	typedef struct packed {
		phase_t      phase;
		logic        negative;
		logic        digit_seen;
		logic [31:0] magnitude;
		logic [31:0] first_value;
		logic        failed;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase:       PH_T,
		negative:    1'b0,
		digit_seen:  1'b0,
		magnitude:   32'd0,
		first_value: 32'd0,
		failed:      1'b0
	};

	typedef struct packed {
		logic        status;
		logic [31:0] tile_x;
		logic [31:0] tile_y;
	} parse_result_t;

endpackage

// File: src/tnp_in_reg.sv
// Input register of the tile name parser: holds one character transfer.
// Depends on nothing but its ports.
module tnp_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] ch,
	input  logic       last,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] ch_s1,
	output logic       last_s1
);

	// Take a new character when the stage is empty or drains this cycle
	assign in_ready = !valid_s1 || advance;

	// Track occupancy of the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the payload of the accepted transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

endmodule

// File: src/tnp_step.sv
// Per-character update of the tile name parser and result forming.
// Depends on tnp_pkg for the state and result types and character codes.
module tnp_step (
	input  tnp_pkg::parse_state_t  cur,
	input  logic [7:0]             ch,
	output tnp_pkg::parse_state_t  nxt,
	output tnp_pkg::parse_result_t res
);

	logic [35:0] mag_ext;
	logic [35:0] prod;
	logic        is_digit;
	logic        cur_ok;
	logic        nxt_ok;
	logic [31:0] cur_val;
	logic [31:0] nxt_val;

	// Scale by ten with two shifts and add the new digit
	assign mag_ext  = {4'd0, cur.magnitude};
	assign prod     = (mag_ext << 3) + (mag_ext << 1) + {32'd0, ch[3:0]};
	assign is_digit = (ch >= tnp_pkg::CH_ZERO) && (ch <= tnp_pkg::CH_NINE);

	// A number needs a digit and, when positive, must stay below 2^31
	assign cur_ok  = cur.digit_seen && (cur.negative || (cur.magnitude <= tnp_pkg::MAG_POS_MAX));
	assign cur_val = cur.negative ? (32'd0 - cur.magnitude) : cur.magnitude;
	assign nxt_ok  = nxt.digit_seen && (nxt.negative || (nxt.magnitude <= tnp_pkg::MAG_POS_MAX));
	assign nxt_val = nxt.negative ? (32'd0 - nxt.magnitude) : nxt.magnitude;

	// Advance the parse by one character; drop everything once failed
	always_comb begin
		nxt = cur;
		if (!cur.failed) begin
			case (cur.phase)
				tnp_pkg::PH_T: begin
					if (ch == tnp_pkg::CH_T) nxt.phase = tnp_pkg::PH_SEP;
					else nxt.failed = 1'b1;
				end
				tnp_pkg::PH_SEP: begin
					if (ch == tnp_pkg::CH_UNDER) begin
						nxt.phase      = tnp_pkg::PH_X;
						nxt.negative   = 1'b0;
						nxt.digit_seen = 1'b0;
						nxt.magnitude  = 32'd0;
					end else begin
						nxt.failed = 1'b1;
					end
				end
				tnp_pkg::PH_X, tnp_pkg::PH_Y: begin
					if (is_digit) begin
						if (prod > {4'd0, tnp_pkg::MAG_LIMIT}) begin
							nxt.failed = 1'b1;
						end else begin
							nxt.magnitude  = prod[31:0];
							nxt.digit_seen = 1'b1;
						end
					end else if (ch == tnp_pkg::CH_MINUS) begin
						if (cur.negative || cur.digit_seen) nxt.failed = 1'b1;
						else nxt.negative = 1'b1;
					end else if ((ch == tnp_pkg::CH_UNDER) && (cur.phase == tnp_pkg::PH_X)) begin
						if (!cur_ok) begin
							nxt.failed = 1'b1;
						end else begin
							nxt.first_value = cur_val;
							nxt.phase       = tnp_pkg::PH_Y;
							nxt.negative    = 1'b0;
							nxt.digit_seen  = 1'b0;
							nxt.magnitude   = 32'd0;
						end
					end else begin
						nxt.failed = 1'b1;
					end
				end
				default: begin
					nxt.failed = 1'b1;
				end
			endcase
		end
	end

	// Form the result as if this character closes the name
	always_comb begin
		if (!nxt.failed && (nxt.phase == tnp_pkg::PH_Y) && nxt_ok) begin
			res.status = 1'b0;
			res.tile_x = nxt.first_value;
			res.tile_y = nxt_val;
		end else begin
			res.status = 1'b1;
			res.tile_x = 32'd0;
			res.tile_y = 32'd0;
		end
	end

endmodule

// File: src/tile_name_parser.sv
// Top level of the tile name parser: input register, parse state, result register.
// Depends on tnp_pkg, tnp_in_reg, tnp_step and assert_macros.svh.
//
// Takes one character of a tile name t_X_Y per transfer and, on the character
// marked last, delivers one result with a status bit (0 good, 1 error) and the
// two signed 32-bit values, both zero on error. A character is taken every
// cycle unless a last character waits for the output; the result of a name is
// registered as its last character leaves the input register. The rate is set
// by the per-character update of the parse state, a times-ten add and a compare
// that close combinationally between the input register and the state register.
// While a result waits to be taken, characters that end no name keep flowing;
// a further last character holds in the input register until the output frees.
`include "assert_macros.svh"

module tile_name_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         ch,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               status,
	output logic signed [31:0] tile_x,
	output logic signed [31:0] tile_y
);

	logic                   valid_s1;
	logic [7:0]             ch_s1;
	logic                   last_s1;
	logic                   advance;
	logic                   out_free;
	tnp_pkg::parse_state_t  state_q;
	tnp_pkg::parse_state_t  state_d;
	tnp_pkg::parse_result_t res;
	logic                   out_valid_q;
	logic                   status_q;
	logic [31:0]            tile_x_q;
	logic [31:0]            tile_y_q;
	logic                   err_vals_zero;
	logic                   state_clear;

	// Consume the staged character unless it ends a name and the output is full
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!last_s1 || out_free);

	tnp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.ch       (ch),
		.last     (last),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.ch_s1    (ch_s1),
		.last_s1  (last_s1)
	);

	tnp_step u_step (
		.cur (state_q),
		.ch  (ch_s1),
		.nxt (state_d),
		.res (res)
	);

	// Update parse state; return to the start after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tnp_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= last_s1 ? tnp_pkg::STATE_RESET : state_d;
		end
	end

	// Track the result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the result payload
	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q <= res.status;
			tile_x_q <= res.tile_x;
			tile_y_q <= res.tile_y;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign tile_x    = tile_x_q;
	assign tile_y    = tile_y_q;

	assign err_vals_zero = (tile_x_q == 32'd0) && (tile_y_q == 32'd0);
	assign state_clear   = (state_q.phase == tnp_pkg::PH_T) && !state_q.failed &&
		(state_q.magnitude == 32'd0);

	// Error results carry zero values
	`ASSERT_PROP(a_err_zero, clk, arst_n, out_valid_q && status_q |-> err_vals_zero)
	// Parse state restarts after a name ends
	`ASSERT_PROP(a_restart, clk, arst_n, advance && last_s1 |=> state_clear)
	// A closing character never overruns a waiting result
	`ASSERT_NEVER(a_no_overrun, clk, arst_n, advance && last_s1 && out_valid_q && !out_ready)
	// Stored magnitude stays within 2^31
	`ASSERT_NEVER(a_mag_range, clk, arst_n, state_q.magnitude > tnp_pkg::MAG_LIMIT)

endmodule
